[rtl/sbj_pkg.sv]
package sbj_pkg;

  // default sizes
  localparam int DEF_MAX_BITS      = 1024;
  localparam int DEF_MAX_SEQUENCES = 64;

  // fixed word geometry
  localparam int WORD_BITS  = 64;
  localparam int WORD_SHIFT = 6;

  // field widths
  localparam int CMD_W      = 3;
  localparam int SEQ_ID_W   = 6;
  localparam int OFFSET_W   = 10;
  localparam int WIDX_W     = 4;
  localparam int START_W    = 11;
  localparam int COUNT_W    = 7;
  localparam int NUM_BITS_W = 11;
  localparam int NUM_SEQ_W  = 7;
  localparam int GAP_W      = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // register reset values
  localparam logic [NUM_BITS_W-1:0] NUM_BITS_RST = 11'd1024;
  localparam logic [NUM_SEQ_W-1:0]  NUM_SEQ_RST  = 7'd0;
  localparam logic [GAP_W-1:0]      MAX_GAP_RST  = 10'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_BITS = 2'd0,
    CFG_NUM_SEQ  = 2'd1,
    CFG_MAX_GAP  = 2'd2
  } cfg_idx_e;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR      = 3'd0,
    CMD_SET_BIT    = 3'd1,
    CMD_WRITE_WORD = 3'd2,
    CMD_SET_START  = 3'd3,
    CMD_SUPPORT    = 3'd4,
    CMD_SSTEP      = 3'd5,
    CMD_ISTEP      = 3'd6,
    CMD_UNUSED     = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ_START,
    ST_EXEC,
    ST_START,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic                 bank;
    logic [SEQ_ID_W-1:0]  seq_id;
    logic [OFFSET_W-1:0]  item_offset;
    logic [WIDX_W-1:0]    word_index;
    logic [WORD_BITS-1:0] word_data;
    logic [START_W-1:0]   seq_start;
  } req_t;

  typedef struct packed {
    logic [COUNT_W-1:0]   count;
    logic [WIDX_W-1:0]    out_index;
    logic [WORD_BITS-1:0] out_word;
    logic                 last;
    logic                 status;
  } rsp_t;

  typedef struct packed {
    logic in_accept;
    logic exec;
    logic scan_start;
    logic issue;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    cmd_e in_cmd;
    cmd_e cmd;
    logic nb_zero;
    logic pos_last;
    logic pos_wend;
    logic out_busy;
    logic pipe_empty;
  } stat_t;

endpackage

[rtl/sbj_if.sv]
interface sbj_req_if;
  logic                           valid;
  logic                           ready;
  logic [sbj_pkg::CMD_W-1:0]      cmd;
  logic                           bank;
  logic [sbj_pkg::SEQ_ID_W-1:0]   seq_id;
  logic [sbj_pkg::OFFSET_W-1:0]   item_offset;
  logic [sbj_pkg::WIDX_W-1:0]     word_index;
  logic [sbj_pkg::WORD_BITS-1:0]  word_data;
  logic [sbj_pkg::START_W-1:0]    seq_start;
  modport source (output valid, cmd, bank, seq_id, item_offset, word_index, word_data,
                  seq_start, input ready);
  modport sink (input valid, cmd, bank, seq_id, item_offset, word_index, word_data,
                seq_start, output ready);
endinterface

interface sbj_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [sbj_pkg::COUNT_W-1:0]    count;
  logic [sbj_pkg::WIDX_W-1:0]     out_index;
  logic [sbj_pkg::WORD_BITS-1:0]  out_word;
  logic                           last;
  logic                           status;
  modport source (output valid, count, out_index, out_word, last, status, input ready);
  modport sink (input valid, count, out_index, out_word, last, status, output ready);
endinterface

interface sbj_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sbj_pkg::CFG_IDX_W-1:0]   index;
  logic [sbj_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/sbj_ram.sv]
module sbj_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

[rtl/sbj_ctrl.sv]
module sbj_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  sbj_pkg::stat_t  stat,
  output sbj_pkg::ctrl_t  ctrl
);
  import sbj_pkg::*;

  state_e state, state_next;
  logic   can_issue;

  // a word end may only enter the scan pipe once the result slot is free
  assign can_issue = !(stat.pos_wend && stat.out_busy);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (stat.in_cmd == CMD_SUPPORT || stat.in_cmd == CMD_SSTEP ||
              stat.in_cmd == CMD_ISTEP) begin
            state_next = ST_START;
          end else if (stat.in_cmd == CMD_SET_BIT) begin
            state_next = ST_READ_START;
          end else begin
            state_next = ST_EXEC;
          end
        end
      end
      ST_READ_START: state_next = ST_EXEC;
      ST_EXEC: begin
        if (!stat.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      ST_START: state_next = stat.nb_zero ? ST_EMIT : ST_SCAN;
      ST_SCAN: begin
        if (can_issue && stat.pos_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (stat.pipe_empty) begin
          state_next = (stat.cmd == CMD_SUPPORT) ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!stat.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready        = (state == ST_IDLE);
    ctrl.in_accept  = (state == ST_IDLE) && in_valid;
    ctrl.exec       = (state == ST_EXEC) && !stat.out_busy;
    ctrl.scan_start = (state == ST_START);
    ctrl.issue      = (state == ST_SCAN) && can_issue;
    ctrl.emit       = (state == ST_EMIT) && !stat.out_busy;
  end
endmodule

[rtl/sbj_datapath.sv]
module sbj_datapath #(
  parameter int MAX_BITS      = sbj_pkg::DEF_MAX_BITS,
  parameter int MAX_SEQUENCES = sbj_pkg::DEF_MAX_SEQUENCES
) (
  input  logic                             clk,
  input  logic                             rst,
  input  sbj_pkg::ctrl_t                   ctrl,
  output sbj_pkg::stat_t                   stat,
  input  sbj_pkg::req_t                    req_in,
  input  logic                             cfg_we,
  input  logic [sbj_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sbj_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output sbj_pkg::rsp_t                    rsp_out
);
  import sbj_pkg::*;

  localparam int NWORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int PW     = $clog2(MAX_BITS);
  localparam int NW     = PW + 1;
  localparam int WW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int SW     = (MAX_SEQUENCES > 1) ? $clog2(MAX_SEQUENCES) : 1;
  localparam int NSW    = $clog2(MAX_SEQUENCES + 1);
  localparam int SPW    = START_W + 1;

  // configuration registers
  logic [NUM_BITS_W-1:0] num_bits;
  logic [NUM_SEQ_W-1:0]  num_sequences;
  logic [GAP_W-1:0]      max_gap;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_bits      <= NUM_BITS_RST;
      num_sequences <= NUM_SEQ_RST;
      max_gap       <= MAX_GAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_e'(cfg_index))
        CFG_NUM_BITS: num_bits      <= cfg_data[NUM_BITS_W-1:0];
        CFG_NUM_SEQ:  num_sequences <= cfg_data[NUM_SEQ_W-1:0];
        CFG_MAX_GAP:  max_gap       <= cfg_data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // saturated sizes
  logic [NW-1:0]  nb_eff;
  logic [NSW-1:0] ns_eff;
  assign nb_eff = (32'(num_bits) > MAX_BITS) ? NW'(MAX_BITS) : NW'(num_bits);
  assign ns_eff = (32'(num_sequences) > MAX_SEQUENCES) ? NSW'(MAX_SEQUENCES)
                                                       : NSW'(num_sequences);

  // command beat
  req_t cmd_q;
  cmd_e cmd;
  always_ff @(posedge clk) begin
    if (ctrl.in_accept) begin
      cmd_q <= req_in;
    end
  end
  assign cmd = cmd_e'(cmd_q.cmd);

  // start table: one copy per lane for the scan, one ram for indexed reads
  logic [START_W-1:0] st_lane [MAX_SEQUENCES];
  logic [START_W-1:0] st_rdata;
  logic               st_we;
  logic               start_ok;

  assign start_ok = 32'(cmd_q.seq_id) < MAX_SEQUENCES;
  assign st_we    = ctrl.exec && (cmd == CMD_SET_START) && start_ok;

  sbj_ram #(
    .WIDTH(START_W),
    .DEPTH(MAX_SEQUENCES)
  ) u_start_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (SW'(cmd_q.seq_id)),
    .wdata (cmd_q.seq_start),
    .re    (ctrl.in_accept && (cmd_e'(req_in.cmd) == CMD_SET_BIT)),
    .raddr (SW'(req_in.seq_id)),
    .rdata (st_rdata)
  );

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_lane[SW'(cmd_q.seq_id)] <= cmd_q.seq_start;
    end
  end

  // single-beat command checks
  logic [SPW-1:0] set_pos;
  logic           set_ok;
  logic           widx_ok;
  logic           exec_status;
  logic [WW-1:0]  set_w;

  assign set_pos = {1'b0, st_rdata} + SPW'(cmd_q.item_offset);
  assign set_ok  = (32'(cmd_q.seq_id) < 32'(ns_eff)) && (32'(set_pos) < 32'(nb_eff));
  assign widx_ok = 32'(cmd_q.word_index) < NWORDS;
  assign set_w   = WW'(set_pos >> WORD_SHIFT);

  always_comb begin
    unique case (cmd)
      CMD_CLEAR:      exec_status = 1'b0;
      CMD_SET_BIT:    exec_status = !set_ok;
      CMD_WRITE_WORD: exec_status = !widx_ok;
      CMD_SET_START:  exec_status = !start_ok;
      default:        exec_status = 1'b1;
    endcase
  end

  // bitmaps
  logic [WORD_BITS-1:0] first_bm  [NWORDS];
  logic [WORD_BITS-1:0] second_bm [NWORDS];
  logic [WORD_BITS-1:0] one_hot;
  assign one_hot = {{(WORD_BITS-1){1'b0}}, 1'b1} << set_pos[WORD_SHIFT-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < NWORDS; w++) begin
        first_bm[w]  <= '0;
        second_bm[w] <= '0;
      end
    end else if (ctrl.exec) begin
      unique case (cmd)
        CMD_CLEAR: begin
          for (int w = 0; w < NWORDS; w++) begin
            first_bm[w]  <= '0;
            second_bm[w] <= '0;
          end
        end
        CMD_SET_BIT: begin
          if (set_ok) begin
            if (cmd_q.bank) begin
              second_bm[set_w] <= second_bm[set_w] | one_hot;
            end else begin
              first_bm[set_w] <= first_bm[set_w] | one_hot;
            end
          end
        end
        CMD_WRITE_WORD: begin
          if (widx_ok) begin
            if (cmd_q.bank) begin
              second_bm[WW'(cmd_q.word_index)] <= cmd_q.word_data;
            end else begin
              first_bm[WW'(cmd_q.word_index)] <= cmd_q.word_data;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // scan position counter
  logic [PW-1:0] p_cnt;
  logic          pos_last;
  logic          pos_wend;
  logic [WW-1:0] scan_w;
  logic          f_bit, s_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_cnt <= '0;
    end else if (ctrl.scan_start) begin
      p_cnt <= '0;
    end else if (ctrl.issue) begin
      p_cnt <= p_cnt + PW'(1);
    end
  end

  assign pos_last = ({1'b0, p_cnt} + NW'(1)) == nb_eff;
  assign pos_wend = (&p_cnt[WORD_SHIFT-1:0]) || pos_last;
  assign scan_w   = WW'(p_cnt >> WORD_SHIFT);
  assign f_bit    = first_bm[scan_w][p_cnt[WORD_SHIFT-1:0]];
  assign s_bit    = second_bm[scan_w][p_cnt[WORD_SHIFT-1:0]];

  // per-lane sequence membership of the current position
  logic [MAX_SEQUENCES:0]   ge;
  logic [MAX_SEQUENCES-1:0] grp;
  always_comb begin
    ge[MAX_SEQUENCES] = 1'b0;
    for (int i = 0; i < MAX_SEQUENCES; i++) begin
      ge[i] = 32'(p_cnt) >= 32'(st_lane[i]);
    end
  end
  always_comb begin
    for (int i = 0; i < MAX_SEQUENCES; i++) begin
      grp[i] = (i < 32'(ns_eff)) && ge[i] && ((i + 1 >= 32'(ns_eff)) || !ge[i+1]);
    end
  end

  // stage 1: membership vector and bitmap bits
  logic                     s1_v;
  logic [PW-1:0]            s1_p;
  logic [MAX_SEQUENCES-1:0] s1_grp;
  logic                     s1_f, s1_sc, s1_b, s1_last, s1_wend;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= ctrl.issue;
    end
  end
  always_ff @(posedge clk) begin
    if (ctrl.issue) begin
      s1_p    <= p_cnt;
      s1_grp  <= grp;
      s1_f    <= f_bit;
      s1_sc   <= s_bit;
      s1_b    <= cmd_q.bank ? s_bit : f_bit;
      s1_last <= pos_last;
      s1_wend <= pos_wend;
    end
  end

  // lowest matching lane wins
  logic [SW-1:0] s_enc;
  logic          s_has;
  always_comb begin
    s_enc = '0;
    for (int i = MAX_SEQUENCES - 1; i >= 0; i--) begin
      if (s1_grp[i]) begin
        s_enc = SW'(i);
      end
    end
    s_has = |s1_grp;
  end

  // stage 2: sequence id, last-first-position lookup in flight
  logic          s2_v;
  logic [PW-1:0] s2_p;
  logic [SW-1:0] s2_s;
  logic          s2_has, s2_f, s2_sc, s2_b, s2_last, s2_wend;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else begin
      s2_v <= s1_v;
    end
  end
  always_ff @(posedge clk) begin
    if (s1_v) begin
      s2_p    <= s1_p;
      s2_s    <= s_enc;
      s2_has  <= s_has;
      s2_f    <= s1_f;
      s2_sc   <= s1_sc;
      s2_b    <= s1_b;
      s2_last <= s1_last;
      s2_wend <= s1_wend;
    end
  end

  // last set position of first, per sequence
  logic [PW-1:0]            lf_rdata;
  logic [MAX_SEQUENCES-1:0] lf_valid;
  logic [MAX_SEQUENCES-1:0] seen;
  logic                     mark_first, mark_seen;
  logic                     bp_v;
  logic [SW-1:0]            bp_s;
  logic [PW-1:0]            bp_p;

  assign mark_first = s2_v && s2_has && s2_f;
  assign mark_seen  = s2_v && s2_has && s2_b && !seen[s2_s];

  sbj_ram #(
    .WIDTH(PW),
    .DEPTH(MAX_SEQUENCES)
  ) u_first_pos_ram (
    .clk   (clk),
    .we    (mark_first),
    .waddr (s2_s),
    .wdata (s2_p),
    .re    (s1_v),
    .raddr (s_enc),
    .rdata (lf_rdata)
  );

  // stage 3: decide, with bypass of the write the ram read just missed
  logic          bp_hit, prev_v;
  logic [PW-1:0] prev_p, gap_dist;
  logic          keep;
  logic [WORD_BITS-1:0] acc, acc_next;
  logic          join_emit;
  logic [NSW-1:0] cnt;

  assign bp_hit   = bp_v && (bp_s == s2_s);
  assign prev_v   = bp_hit || lf_valid[s2_s];
  assign prev_p   = bp_hit ? bp_p : lf_rdata;
  assign gap_dist = s2_p - prev_p;
  assign keep     = s2_has && s2_sc &&
                    ((cmd == CMD_SSTEP) ? (prev_v && (32'(gap_dist) <= 32'(max_gap)))
                                        : s2_f);
  assign acc_next  = acc | ({{(WORD_BITS-1){1'b0}}, keep} << s2_p[WORD_SHIFT-1:0]);
  assign join_emit = s2_v && s2_wend && (cmd != CMD_SUPPORT);

  always_ff @(posedge clk) begin
    if (rst) begin
      lf_valid <= '0;
      seen     <= '0;
      bp_v     <= 1'b0;
      cnt      <= '0;
    end else if (ctrl.scan_start) begin
      lf_valid <= '0;
      seen     <= '0;
      bp_v     <= 1'b0;
      cnt      <= '0;
    end else begin
      if (mark_first) begin
        lf_valid[s2_s] <= 1'b1;
        bp_v           <= 1'b1;
      end
      if (mark_seen) begin
        seen[s2_s] <= 1'b1;
        cnt        <= cnt + NSW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mark_first) begin
      bp_s <= s2_s;
      bp_p <= s2_p;
    end
  end

  // word accumulator
  always_ff @(posedge clk) begin
    if (ctrl.scan_start) begin
      acc <= '0;
    end else if (s2_v) begin
      acc <= s2_wend ? '0 : acc_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.exec || ctrl.emit || join_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      rsp_out.count     <= '0;
      rsp_out.out_index <= '0;
      rsp_out.out_word  <= '0;
      rsp_out.last      <= 1'b1;
      rsp_out.status    <= exec_status;
    end else if (ctrl.emit) begin
      rsp_out.count     <= COUNT_W'(cnt);
      rsp_out.out_index <= '0;
      rsp_out.out_word  <= '0;
      rsp_out.last      <= 1'b1;
      rsp_out.status    <= 1'b0;
    end else if (join_emit) begin
      rsp_out.count     <= '0;
      rsp_out.out_index <= WIDX_W'(s2_p >> WORD_SHIFT);
      rsp_out.out_word  <= acc_next;
      rsp_out.last      <= s2_last;
      rsp_out.status    <= 1'b0;
    end
  end

  // status to the controller
  always_comb begin
    stat.in_cmd     = cmd_e'(req_in.cmd);
    stat.cmd        = cmd;
    stat.nb_zero    = (nb_eff == '0);
    stat.pos_last   = pos_last;
    stat.pos_wend   = pos_wend;
    stat.out_busy   = out_valid || (s1_v && s1_wend) || (s2_v && s2_wend);
    stat.pipe_empty = !s1_v && !s2_v;
  end
endmodule

[rtl/sequence_bitmap_join_engine_top.sv]
// channel  | dir | beat carries
// ---------+-----+---------------------------------------------------------
// cfg      | in  | index (0 num_bits, 1 num_sequences, 2 max_gap), data
// req      | in  | cmd, bank, seq_id, item_offset, word_index, word_data, seq_start
// rsp      | out | count, out_index, out_word, last, status
//
// clear, write word, set start and unused codes execute directly; set bit reads
// the start table ram first. support and both joins scan one bit position per
// cycle through a three-stage scan pipe; support then emits its count.
// a full result register stalls the scan at each word end until the word is taken.
// rst is synchronous: bitmaps clear, registers return to their defaults.
// cfg is always ready; one request is in work at a time.
module sequence_bitmap_join_engine_top #(
  parameter int MAX_BITS      = sbj_pkg::DEF_MAX_BITS,
  parameter int MAX_SEQUENCES = sbj_pkg::DEF_MAX_SEQUENCES
) (
  input  logic      clk,
  input  logic      rst,
  sbj_cfg_if.sink   cfg,
  sbj_req_if.sink   req,
  sbj_rsp_if.source rsp
);
  import sbj_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  req_t  req_in;
  rsp_t  rsp_out;
  logic  in_ready;
  logic  out_valid;

  // request payload
  always_comb begin
    req_in.cmd         = req.cmd;
    req_in.bank        = req.bank;
    req_in.seq_id      = req.seq_id;
    req_in.item_offset = req.item_offset;
    req_in.word_index  = req.word_index;
    req_in.word_data   = req.word_data;
    req_in.seq_start   = req.seq_start;
  end

  assign req.ready     = in_ready;
  assign cfg.ready     = 1'b1;
  assign rsp.valid     = out_valid;
  assign rsp.count     = rsp_out.count;
  assign rsp.out_index = rsp_out.out_index;
  assign rsp.out_word  = rsp_out.out_word;
  assign rsp.last      = rsp_out.last;
  assign rsp.status    = rsp_out.status;

  sbj_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  sbj_datapath #(
    .MAX_BITS      (MAX_BITS),
    .MAX_SEQUENCES (MAX_SEQUENCES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .stat      (stat),
    .req_in    (req_in),
    .cfg_we    (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .out_valid (out_valid),
    .out_ready (rsp.ready),
    .rsp_out   (rsp_out)
  );
endmodule

[rtl/sbj_checker.sv]
module sbj_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_last,
  input logic                           out_status,
  input logic [sbj_pkg::COUNT_W-1:0]    out_count,
  input logic [sbj_pkg::WORD_BITS-1:0]  out_word
);
  import sbj_pkg::*;

  // a result beat waits until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before it was taken");

  // one request in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one in work");

  // only join words come before the final beat
  a_mid_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> !out_status && out_count == '0)
    else $error("non-final beat with status or count");

  // ignored requests give a single empty beat
  a_ignored: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status |-> out_last && out_word == '0)
    else $error("ignored request with data or not final");
endmodule

bind sequence_bitmap_join_engine_top sbj_checker u_sbj_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (req.valid),
  .in_ready   (req.ready),
  .out_valid  (rsp.valid),
  .out_ready  (rsp.ready),
  .out_last   (rsp.last),
  .out_status (rsp.status),
  .out_count  (rsp.count),
  .out_word   (rsp.out_word)
);

[tb/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sbj_pkg::*;

  // scoreboard: bitmap predictor plus queue of expected result beats
  class join_scoreboard;
    logic [WORD_BITS-1:0] first_map [16];
    logic [WORD_BITS-1:0] second_map [16];
    logic [START_W-1:0]   start_pos [64];
    logic [NUM_BITS_W-1:0] num_bits;
    logic [NUM_SEQ_W-1:0]  num_seq;
    logic [GAP_W-1:0]      max_gap;
    rsp_t expected_rsp [$];
    int   owner [1024];
    int   errors;
    int   beats_checked;
    int   requests_seen;

    function void clear_state();
      for (int w = 0; w < 16; w++) begin
        first_map[w] = '0;
        second_map[w] = '0;
      end
      for (int i = 0; i < 64; i++) start_pos[i] = '0;
      num_bits = NUM_BITS_RST;
      num_seq = NUM_SEQ_RST;
      max_gap = MAX_GAP_RST;
      errors = 0;
      beats_checked = 0;
      requests_seen = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_NUM_BITS: num_bits = data[NUM_BITS_W-1:0];
        CFG_NUM_SEQ:  num_seq = data[NUM_SEQ_W-1:0];
        CFG_MAX_GAP:  max_gap = data[GAP_W-1:0];
        default: ;
      endcase
    endfunction

    // append one expected beat
    function void queue_beat(rsp_t b);
      expected_rsp = {expected_rsp, b};
    endfunction

    function bit bit_at(bit use_second, int p);
      if (use_second) return second_map[p / 64][p % 64];
      return first_map[p / 64][p % 64];
    endfunction

    // sequence owning each position, lowest matching entry wins
    function void map_positions(int nb, int ns);
      for (int p = 0; p < nb; p++) begin
        owner[p] = -1;
        for (int i = 0; i < ns; i++) begin
          if (p >= start_pos[i] && (i + 1 >= ns || p < start_pos[i + 1])) begin
            owner[p] = i;
            break;
          end
        end
      end
    endfunction

    function void note_request(req_t r);
      int nb, ns, p, cnt, nw;
      bit seen [64];
      bit keep;
      logic [WORD_BITS-1:0] res [16];
      rsp_t x;
      nb = (num_bits > 1024) ? 1024 : num_bits;
      ns = (num_seq > 64) ? 64 : num_seq;
      x = '0;
      x.last = 1'b1;
      requests_seen++;
      case (r.cmd)
        CMD_CLEAR: begin
          for (int w = 0; w < 16; w++) begin
            first_map[w] = '0;
            second_map[w] = '0;
          end
          queue_beat(x);
        end
        CMD_SET_BIT: begin
          p = start_pos[r.seq_id] + r.item_offset;
          if (r.seq_id >= ns || p >= nb) begin
            x.status = 1'b1;
          end else if (r.bank) begin
            second_map[p / 64][p % 64] = 1'b1;
          end else begin
            first_map[p / 64][p % 64] = 1'b1;
          end
          queue_beat(x);
        end
        CMD_WRITE_WORD: begin
          if (r.bank) second_map[r.word_index] = r.word_data;
          else first_map[r.word_index] = r.word_data;
          queue_beat(x);
        end
        CMD_SET_START: begin
          start_pos[r.seq_id] = r.seq_start;
          queue_beat(x);
        end
        CMD_SUPPORT: begin
          cnt = 0;
          for (int i = 0; i < 64; i++) seen[i] = 0;
          map_positions(nb, ns);
          for (p = 0; p < nb; p++) begin
            if (owner[p] >= 0 && bit_at(r.bank, p) && !seen[owner[p]]) begin
              seen[owner[p]] = 1;
              cnt++;
            end
          end
          x.count = COUNT_W'(cnt);
          queue_beat(x);
        end
        CMD_SSTEP, CMD_ISTEP: begin
          for (int w = 0; w < 16; w++) res[w] = '0;
          map_positions(nb, ns);
          for (p = 0; p < nb; p++) begin
            if (owner[p] < 0 || !bit_at(1, p)) continue;
            keep = 0;
            if (r.cmd == CMD_ISTEP) begin
              keep = bit_at(0, p);
            end else begin
              for (int q = 1; q <= max_gap && q <= p; q++) begin
                if (owner[p - q] == owner[p] && bit_at(0, p - q)) begin
                  keep = 1;
                  break;
                end
              end
            end
            if (keep) res[p / 64][p % 64] = 1'b1;
          end
          nw = (nb + 63) / 64;
          if (nw == 0) nw = 1;
          for (int w = 0; w < nw; w++) begin
            x = '0;
            x.out_index = WIDX_W'(w);
            x.out_word = res[w];
            x.last = (w + 1 == nw);
            queue_beat(x);
          end
        end
        default: begin
          x.status = 1'b1;
          queue_beat(x);
        end
      endcase
    endfunction

    function void check_result(rsp_t got);
      rsp_t exp;
      beats_checked++;
      if (expected_rsp.size() == 0) begin
        $display("%0t: unexpected result beat %p", $time, got);
        errors++;
        return;
      end
      exp = expected_rsp.pop_front();
      if (got.count !== exp.count)
        $display("%0t: count expected %0d actual %0d", $time, exp.count, got.count);
      if (got.out_index !== exp.out_index)
        $display("%0t: out_index expected %0d actual %0d", $time, exp.out_index,
                 got.out_index);
      if (got.out_word !== exp.out_word)
        $display("%0t: out_word expected %h actual %h", $time, exp.out_word, got.out_word);
      if (got.last !== exp.last)
        $display("%0t: last expected %b actual %b", $time, exp.last, got.last);
      if (got.status !== exp.status)
        $display("%0t: status expected %b actual %b", $time, exp.status, got.status);
      if (got !== exp) errors++;
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 3000000;

  logic clk;
  logic rst;
  int   cycles = 0;
  bit   quiet;
  bit   long_hold;

  sbj_cfg_if cfg ();
  sbj_req_if req ();
  sbj_rsp_if rsp ();

  join_scoreboard sb;

  sequence_bitmap_join_engine_top DUT (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .req (req),
    .rsp (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL sequence_bitmap_join_engine_top");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready)
      sb.check_result({rsp.count, rsp.out_index, rsp.out_word, rsp.last, rsp.status});
  end

  // receiver: random stalls after each beat, one long hold on request
  initial begin
    int n;
    rsp.ready = 1'b0;
    @(negedge rst);
    @(posedge clk);
    rsp.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        rsp.ready <= 1'b0;
        repeat (600) @(posedge clk);
        rsp.ready <= 1'b1;
        long_hold = 0;
      end else if (rsp.valid && rsp.ready) begin
        n = quiet ? 0 : $urandom_range(0, 11);
        if (n > 0) begin
          rsp.ready <= 1'b0;
          repeat (n) @(posedge clk);
          rsp.ready <= 1'b1;
        end
      end
    end
  end

  task automatic send_req(req_t r);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.cmd <= r.cmd;
    req.bank <= r.bank;
    req.seq_id <= r.seq_id;
    req.item_offset <= r.item_offset;
    req.word_index <= r.word_index;
    req.word_data <= r.word_data;
    req.seq_start <= r.seq_start;
    req.valid <= 1'b1;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sb.note_request(r);
  endtask

  // the chosen command, with random filler in every other field
  function automatic req_t make_req(logic [CMD_W-1:0] c);
    req_t r;
    r.cmd = c;
    r.bank = 1'($urandom_range(0, 1));
    r.seq_id = SEQ_ID_W'($urandom);
    r.item_offset = OFFSET_W'($urandom);
    r.word_index = WIDX_W'($urandom);
    r.word_data = {$urandom, $urandom};
    r.seq_start = START_W'($urandom_range(0, 1024));
    return r;
  endfunction

  task automatic send_cmd(logic [CMD_W-1:0] c);
    send_req(make_req(c));
  endtask

  task automatic send_set_bit(bit bank, int sid, int off);
    req_t r;
    r = make_req(CMD_SET_BIT);
    r.bank = bank;
    r.seq_id = SEQ_ID_W'(sid);
    r.item_offset = OFFSET_W'(off);
    send_req(r);
  endtask

  task automatic send_word(bit bank, int idx, logic [WORD_BITS-1:0] data);
    req_t r;
    r = make_req(CMD_WRITE_WORD);
    r.bank = bank;
    r.word_index = WIDX_W'(idx);
    r.word_data = data;
    send_req(r);
  endtask

  task automatic send_start(int sid, int pos);
    req_t r;
    r = make_req(CMD_SET_START);
    r.seq_id = SEQ_ID_W'(sid);
    r.seq_start = START_W'(pos);
    send_req(r);
  endtask

  task automatic send_query(logic [CMD_W-1:0] c, bit bank);
    req_t r;
    r = make_req(c);
    r.bank = bank;
    send_req(r);
  endtask

  // wait until every expected beat is in, then let the block settle
  task automatic drain();
    req.valid <= 1'b0;
    while (sb.expected_rsp.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, int data);
    cfg.index <= idx;
    cfg.data <= CFG_DATA_W'(data);
    cfg.valid <= 1'b1;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    sb.write_reg(idx, CFG_DATA_W'(data));
  endtask

  // sorted start table for entries below ns, loaded before ns is raised
  task automatic load_starts(int nb, int ns);
    int pos, step;
    pos = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : 0;
    step = (ns > 0) ? (2 * nb / ns + 1) : 1;
    for (int i = 0; i < ns; i++) begin
      if (pos > 1024) pos = 1024;
      send_start(i, pos);
      pos += $urandom_range(0, step);
    end
  endtask

  // one random phase under a fixed register setting
  task automatic run_phase(int nb_raw, int ns_raw, int gap, int items);
    int nb, ns, pick, span;
    nb = (nb_raw > 1024) ? 1024 : nb_raw;
    ns = (ns_raw > 64) ? 64 : ns_raw;
    drain();
    write_reg(CFG_NUM_SEQ, 0);
    write_reg(CFG_NUM_BITS, nb_raw);
    write_reg(CFG_MAX_GAP, gap);
    load_starts(nb, ns);
    drain();
    write_reg(CFG_NUM_SEQ, ns_raw);
    span = (ns > 0) ? (2 * nb / ns + 2) : 4;
    for (int k = 0; k < items; k++) begin
      quiet = (k % 20) >= 15;
      pick = $urandom_range(0, 99);
      if (pick < 2) send_cmd(CMD_CLEAR);
      else if (pick < 4) send_cmd(CMD_UNUSED);
      else if (pick < 30) begin
        if ($urandom_range(0, 7) == 0) send_set_bit($urandom_range(0, 1), $urandom_range(0, 63),
                                                    $urandom_range(0, 1023));
        else send_set_bit($urandom_range(0, 1), (ns > 0) ? $urandom_range(0, ns - 1) : 0,
                          $urandom_range(0, span));
      end else if (pick < 42) begin
        send_word($urandom_range(0, 1), $urandom_range(0, 15),
                  ($urandom_range(0, 1)) ? {$urandom, $urandom} & {$urandom, $urandom}
                                         : {$urandom, $urandom});
      end else if (pick < 47) begin
        // mostly move starts to positions within nb
        if (ns > 0 && $urandom_range(0, 3) != 0) send_start($urandom_range(0, 63),
                                                            $urandom_range(0, nb));
        else send_start($urandom_range(0, 63), $urandom_range(0, 1024));
      end else if (pick < 62) send_query(CMD_SUPPORT, $urandom_range(0, 1));
      else if (pick < 82) send_query(CMD_SSTEP, $urandom_range(0, 1));
      else send_query(CMD_ISTEP, $urandom_range(0, 1));
      if (k == items / 2 && ns_raw == 8) begin
        // block fills up while results are held back
        long_hold = 1;
      end
      if (k == items / 2 && ns_raw == 16) drain();
    end
    quiet = 0;
  endtask

  initial begin
    sb = new();
    sb.clear_state();
    quiet = 0;
    long_hold = 0;
    rst = 1'b1;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    req.valid = 1'b0;
    req.cmd = '0;
    req.bank = 1'b0;
    req.seq_id = '0;
    req.item_offset = '0;
    req.word_index = '0;
    req.word_data = '0;
    req.seq_start = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: no sequences, unused code, ignored bit, extreme words
    send_query(CMD_SUPPORT, 0);
    send_query(CMD_SSTEP, 0);
    send_query(CMD_ISTEP, 1);
    send_cmd(CMD_UNUSED);
    send_set_bit(0, 0, 0);
    send_word(0, 0, '1);
    send_word(1, 15, '1);
    send_word(1, 0, 64'h8000_0000_0000_0001);
    send_start(0, 0);
    send_start(1, 10);
    send_start(2, 20);
    send_start(3, 1024);
    send_start(63, 1024);
    drain();
    write_reg(CFG_NUM_BITS, 2047);
    write_reg(CFG_NUM_SEQ, 4);
    write_reg(CFG_MAX_GAP, 1023);
    send_set_bit(1, 3, 0);
    send_set_bit(0, 5, 1);
    send_set_bit(1, 2, 1023);
    send_set_bit(0, 1, 1023);
    send_set_bit(1, 0, 5);
    send_query(CMD_SUPPORT, 0);
    send_query(CMD_SUPPORT, 1);
    send_query(CMD_SSTEP, 0);
    send_query(CMD_ISTEP, 0);
    send_cmd(CMD_CLEAR);
    send_query(CMD_ISTEP, 0);

    // random phases across register settings, extremes included
    run_phase(64, 1, 0, 25);
    run_phase(1, 64, 1, 20);
    run_phase(200, 8, 3, 30);
    run_phase(100, 127, 1023, 20);
    run_phase(300, 16, 5, 30);
    run_phase(130, 3, 2, 25);
    run_phase($urandom_range(1, 400), $urandom_range(0, 20), $urandom_range(0, 40), 25);
    run_phase(1024, 32, 7, 15);
    drain();

    $display("checked %0d result beats from %0d requests over ten register settings",
             sb.beats_checked, sb.requests_seen);
    $display("covered set/clear/word/start updates, support and both joins, ignored requests");
    if (sb.errors == 0 && sb.expected_rsp.size() == 0) begin
      $display("PASS sequence_bitmap_join_engine_top");
    end else begin
      $display("FAIL sequence_bitmap_join_engine_top");
    end
    $finish;
  end
endmodule

[files.f]
rtl/sbj_pkg.sv
rtl/sbj_if.sv
rtl/sbj_ram.sv
rtl/sbj_ctrl.sv
rtl/sbj_datapath.sv
rtl/sequence_bitmap_join_engine_top.sv
rtl/sbj_checker.sv
tb/tb.sv
